// File: hdl/bgd_pkg.sv
package bgd_pkg;

   localparam int TIME_W      = 32;
   localparam int HOLD_BITS   = 4;
   localparam int HOLD_REGS   = 4;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEBOUNCE_TIME   = 3'd0,
      REG_REPEAT_INTERVAL = 3'd1,
      REG_CLICK_WINDOW    = 3'd2,
      REG_HOLD_COUNT      = 3'd3,
      REG_HOLD_TIME_0     = 3'd4,
      REG_HOLD_TIME_1     = 3'd5,
      REG_HOLD_TIME_2     = 3'd6,
      REG_HOLD_TIME_3     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CLICK_NONE   = 2'd0,
      CLICK_SINGLE = 2'd1,
      CLICK_DOUBLE = 2'd2,
      CLICK_TRIPLE = 2'd3
   } click_kind_type;

   localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 32'd50;
   localparam logic [TIME_W-1:0]  REPEAT_RESET   = 32'd0;
   localparam logic [TIME_W-1:0]  WINDOW_RESET   = 32'd300;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 3'd0;

   typedef struct packed {
      logic              raw_level;
      logic [TIME_W-1:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic                 pressed;
      logic                 press_event;
      logic                 release_event;
      logic [HOLD_BITS-1:0] hold_fired;
      logic                 repeat_event;
      logic [1:0]           click_kind;
   } rsp_payload_type;

   // Reset value of a hold threshold; slots past the register map read zero.
   function automatic logic [TIME_W-1:0] hold_time_reset(input int slot);
      logic [TIME_W-1:0] value;
      case (slot)
         0:       value = 32'd1000;
         1:       value = 32'd2000;
         2:       value = 32'd3000;
         3:       value = 32'd5000;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// File: hdl/bgd_stream_if.sv
interface bgd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/button_gesture_detector.sv
// Button gesture detector. Each request carries one raw button sample and a
// free-running 32-bit millisecond timestamp, and produces exactly one response
// with the debounced state, press and release edges, hold threshold and
// hold-repeat events and the click kind. The whole decision is made in one
// pass of compare logic between the request channel and a single response
// register, so the response appears in the cycle after its request is taken
// and the sustained rate is one request per clock, limited only by the
// response channel being stalled while its register is full. All time
// differences are taken modulo two to the 32, so the timestamp may wrap
// freely. Settings are written through the csr_ port and should only change
// while no request is in flight.
module button_gesture_detector #(
   parameter int HOLD_SLOTS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   bgd_stream_if.sink                          req_chan,
   bgd_stream_if.source                        rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bgd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bgd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TW = bgd_pkg::TIME_W;

   // Settings registers.
   logic [TW-1:0]               debounce_ff;
   logic [TW-1:0]               repeat_ff;
   logic [TW-1:0]               window_ff;
   logic [bgd_pkg::COUNT_W-1:0] hold_count_ff;
   logic [TW-1:0]               hold_time_ff [HOLD_SLOTS];

   // Gesture state.
   logic                  last_level_ff, last_level_in;
   logic [TW-1:0]         change_time_ff, change_time_in;
   logic                  settling_ff, settling_in;
   logic                  stable_ff, stable_in;
   logic [TW-1:0]         press_time_ff, press_time_in;
   logic [TW-1:0]         repeat_time_ff, repeat_time_in;
   logic                  hold_used_ff, hold_used_in;
   logic [HOLD_SLOTS-1:0] done_ff, done_in;
   logic [1:0]            tally_ff, tally_in;
   logic [TW-1:0]         release_time_ff, release_time_in;

   // Response register.
   logic                     rsp_valid_ff;
   bgd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                  req_fire;
   logic                  raw;
   logic [TW-1:0]         now;
   logic [TW-1:0]         settle_age;
   logic [TW-1:0]         held;
   logic [TW-1:0]         repeat_age;
   logic [TW-1:0]         release_age;
   logic                  settle_open;
   logic                  still_settling;
   logic                  press_edge;
   logic                  release_edge;
   logic                  hold_used_mid;
   logic [HOLD_SLOTS-1:0] done_mid;
   logic [HOLD_SLOTS-1:0] fire;
   logic [1:0]            tally_mid;
   logic                  repeat_hit;
   logic                  click_due;
   logic [bgd_pkg::HOLD_BITS-1:0] fired_bits;

   // The response register frees up in the same cycle it is emptied, so the
   // request side only waits while a response is both present and stalled.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign raw            = req_chan.payload.raw_level;
   assign now            = req_chan.payload.time_ms;

   // ---------------------------------------------------------------------
   // Settings port. Hold thresholds are handled per slot further down.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bgd_pkg::DEBOUNCE_RESET;
         repeat_ff     <= bgd_pkg::REPEAT_RESET;
         window_ff     <= bgd_pkg::WINDOW_RESET;
         hold_count_ff <= bgd_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bgd_pkg::REG_DEBOUNCE_TIME:   debounce_ff   <= csr_wdata;
            bgd_pkg::REG_REPEAT_INTERVAL: repeat_ff     <= csr_wdata;
            bgd_pkg::REG_CLICK_WINDOW:    window_ff     <= csr_wdata;
            bgd_pkg::REG_HOLD_COUNT:      hold_count_ff <= csr_wdata[bgd_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Only the first four slots have a register index; any further slots keep
   // a threshold of zero, so they fire on the press itself when in use.
   for (genvar s = 0; s < HOLD_SLOTS; s++) begin : g_slot
      if (s < bgd_pkg::HOLD_REGS) begin : g_writable
         localparam logic [bgd_pkg::CSR_INDEX_W-1:0] SLOT_INDEX =
            bgd_pkg::CSR_INDEX_W'(int'(bgd_pkg::REG_HOLD_TIME_0) + s);
         always_ff @(posedge clock) begin
            if (reset) begin
               hold_time_ff[s] <= bgd_pkg::hold_time_reset(s);
            end else if (csr_wr_en && csr_index == SLOT_INDEX) begin
               hold_time_ff[s] <= csr_wdata;
            end
         end
      end else begin : g_fixed
         always_ff @(posedge clock) begin
            hold_time_ff[s] <= '0;
         end
      end

      // A slot is in use when its number is below hold_count; counts above
      // the number of slots therefore simply enable every slot.
      assign fire[s] = ({1'b0, hold_count_ff} > (bgd_pkg::COUNT_W + 1)'(s)) &&
                       stable_in && !done_mid[s] && (held >= hold_time_ff[s]);
   end

   // Only the first four thresholds are reported in hold_fired.
   for (genvar b = 0; b < bgd_pkg::HOLD_BITS; b++) begin : g_fired
      if (b < HOLD_SLOTS) begin : g_present
         assign fired_bits[b] = fire[b];
      end else begin : g_absent
         assign fired_bits[b] = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Gesture decision for the request being taken this cycle.
   // ---------------------------------------------------------------------
   assign settle_age  = now - change_time_in;
   assign held        = now - press_time_in;
   // Measured from the stored reference; on a press edge the held time is
   // zero, so no tick can be due there whatever this age reads.
   assign repeat_age  = now - repeat_time_ff;
   assign release_age = now - release_time_in;

   always_comb begin
      // Any change of the raw level restarts the settling time.
      last_level_in  = raw;
      change_time_in = (raw != last_level_ff) ? now : change_time_ff;
      settle_open    = settling_ff || (raw != last_level_ff);
      still_settling = settle_open && (settle_age < debounce_ff);
      settling_in    = still_settling;

      press_edge   = !still_settling && raw && !stable_ff;
      release_edge = !still_settling && !raw && stable_ff;

      stable_in       = stable_ff;
      press_time_in   = press_time_ff;
      hold_used_mid   = hold_used_ff;
      done_mid        = done_ff;
      tally_mid       = tally_ff;
      release_time_in = release_time_ff;

      if (press_edge) begin
         stable_in     = 1'b1;
         press_time_in = now;
         hold_used_mid = 1'b0;
         done_mid      = '0;
      end else if (release_edge) begin
         stable_in = 1'b0;
         // A release that ends a hold gesture is not counted as a click.
         if (!hold_used_ff) begin
            if (tally_ff != 2'(bgd_pkg::CLICK_TRIPLE)) begin
               tally_mid = tally_ff + 2'd1;
            end
            release_time_in = now;
         end
      end

      // Repeat ticks start one full interval after the press and then run
      // one interval apart; a zero interval switches them off.
      repeat_hit = !still_settling && stable_in && (repeat_ff != '0) &&
                   (held >= repeat_ff) && (repeat_age >= repeat_ff);

      // The click count is reported once the window after the last counted
      // release has run out with the button still up.
      click_due = !still_settling && !stable_in && (tally_mid != '0) &&
                  (release_age >= window_ff);

      if (still_settling) begin
         done_in      = done_ff;
         hold_used_in = hold_used_ff;
      end else begin
         done_in      = done_mid | fire;
         hold_used_in = hold_used_mid || (fire != '0);
      end
      tally_in = click_due ? 2'(bgd_pkg::CLICK_NONE) : tally_mid;

      rsp_payload_in.pressed       = stable_in;
      rsp_payload_in.press_event   = press_edge;
      rsp_payload_in.release_event = release_edge;
      rsp_payload_in.hold_fired    = still_settling ? '0 : fired_bits;
      rsp_payload_in.repeat_event  = repeat_hit;
      rsp_payload_in.click_kind    = click_due ? tally_mid : 2'(bgd_pkg::CLICK_NONE);
   end

   // The repeat reference moves with the press and with every tick.
   assign repeat_time_in = press_edge ? now : (repeat_hit ? now : repeat_time_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff   <= 1'b0;
         change_time_ff  <= '0;
         settling_ff     <= 1'b0;
         stable_ff       <= 1'b0;
         press_time_ff   <= '0;
         repeat_time_ff  <= '0;
         hold_used_ff    <= 1'b0;
         done_ff         <= '0;
         tally_ff        <= '0;
         release_time_ff <= '0;
      end else if (req_fire) begin
         last_level_ff   <= last_level_in;
         change_time_ff  <= change_time_in;
         settling_ff     <= settling_in;
         stable_ff       <= stable_in;
         press_time_ff   <= press_time_in;
         repeat_time_ff  <= repeat_time_in;
         hold_used_ff    <= hold_used_in;
         done_ff         <= done_in;
         tally_ff        <= tally_in;
         release_time_ff <= release_time_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // Every request taken yields a response in the following cycle.
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid)
      else $error("request taken without a response following");

   // A press edge always leaves the button reported as pressed.
   a_press_is_pressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.press_event) |-> rsp_chan.payload.pressed)
      else $error("press event reported while released");

   // Clicks are only reported with the button up.
   a_click_when_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.click_kind != 2'(bgd_pkg::CLICK_NONE))
      |-> !rsp_chan.payload.pressed)
      else $error("click reported while pressed");

   // Hold thresholds fire only while the button is held.
   a_hold_when_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.hold_fired != '0) |-> rsp_chan.payload.pressed)
      else $error("hold threshold fired while released");
`endif

endmodule
